### src/tama_pkg.sv
package tama_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int MEAN_W            = 20;
  localparam int USED_W            = 4;
  localparam int AXES              = 3;
  localparam int WINDOW_DEFAULT    = 10;
  localparam int FRAC_BITS_DEFAULT = 4;
  localparam int MEAN_MAX          = 524287;
  localparam int MEAN_MIN          = -524288;
  localparam int USED_MAX          = 15;
  localparam int IN_DATA_W         = 48;
  localparam int OUT_DATA_W        = 64;

endpackage

### src/tama_ram.sv
module tama_ram import tama_pkg::*; #(
  parameter int WIDTH = IN_DATA_W,
  parameter int DEPTH = WINDOW_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/three_axis_moving_average.sv
// three-axis moving average over the last WINDOW samples
//
// input stream s_*: one transfer carries one sample triple (x, y, z), each a
// signed 16-bit reading. output stream m_*: one transfer per input transfer,
// carrying the three window means with FRAC_BITS fraction bits (truncated
// toward zero, saturated to 20 bits) and the number of samples averaged.
//
// each item goes from the input transfer through a ring read and a division
// of QW quotient bits to the output register, where QW = 17 + clog2(WINDOW) +
// FRAC_BITS (25 for the default window of 10 and four fraction bits). the
// next input transfer is taken once the output register is loaded. the
// restoring divider develops one quotient bit per cycle on all three
// axes at once. one item is in work at a time; s_tready is high only while idle.
//
// a finished result sits in the output register; a new sample is taken
// while it waits, and the next result is held back until m_tready takes the
// pending one. reset (rst, synchronous) clears the sums, the slot pointer and
// the fill count, so the first results average fewer samples; the ring
// contents need no clearing since an entry is read only after it is written.
module three_axis_moving_average import tama_pkg::*; #(
  parameter int WINDOW    = WINDOW_DEFAULT,
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // sample_x, sample_y, sample_z
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // mean_x, mean_y, mean_z, samples_used
);

  localparam int SLOT_W = WINDOW > 1 ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + 1 + $clog2(WINDOW);
  localparam int QW     = SUM_W + FRAC_BITS;
  localparam int BIT_W  = $clog2(QW + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t                state;
  logic [SLOT_W-1:0]     slot;
  logic [CNT_W-1:0]      count;
  logic signed [SUM_W-1:0] sum [AXES];
  logic [IN_DATA_W-1:0]  sample;
  logic [QW-1:0]         dvd [AXES];
  logic [CNT_W-1:0]      rem [AXES];
  logic                  neg [AXES];
  logic [BIT_W-1:0]      bit_cnt;

  logic [IN_DATA_W-1:0]  old_data;
  logic                  full;
  logic                  ram_wr;
  logic signed [SUM_W-1:0] sum_next [AXES];
  logic signed [QW-1:0]  scaled [AXES];
  logic [QW-1:0]         mag [AXES];
  logic [CNT_W:0]        trial [AXES];
  logic                  ge [AXES];
  logic [CNT_W-1:0]      rem_next [AXES];
  logic signed [QW:0]    quot [AXES];
  logic [MEAN_W-1:0]     mean [AXES];
  logic [USED_W-1:0]     used;
  logic [SLOT_W-1:0]     slot_next;
  logic [CNT_W-1:0]      count_next;

  assign s_tready = (state == ST_IDLE);
  assign full     = (count == CNT_W'(WINDOW));
  assign ram_wr   = (state == ST_READ);

  tama_ram #(
    .WIDTH(IN_DATA_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk    (clk),
    .wr_en  (ram_wr),
    .wr_addr(slot),
    .wr_data(sample),
    .rd_addr(slot),
    .rd_data(old_data)
  );

  assign slot_next  = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + SLOT_W'(1);
  assign count_next = full ? count : count + CNT_W'(1);
  assign used       = (32'(count) > USED_MAX) ? USED_W'(USED_MAX) : USED_W'(count);

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sum_next[a] = sum[a]
                  - (full ? SUM_W'($signed(old_data[a*SAMPLE_W +: SAMPLE_W])) : '0)
                  + SUM_W'($signed(sample[a*SAMPLE_W +: SAMPLE_W]));
      scaled[a]   = QW'(sum_next[a]) <<< FRAC_BITS;
      mag[a]      = scaled[a][QW-1] ? QW'(-scaled[a]) : QW'(scaled[a]);
      trial[a]    = {rem[a], dvd[a][QW-1]};
      ge[a]       = (trial[a] >= {1'b0, count});
      rem_next[a] = ge[a] ? CNT_W'(trial[a] - {1'b0, count}) : trial[a][CNT_W-1:0];
      quot[a]     = neg[a] ? -$signed({1'b0, dvd[a]}) : $signed({1'b0, dvd[a]});
      if (quot[a] > (QW + 1)'(MEAN_MAX)) begin
        mean[a] = MEAN_W'(MEAN_MAX);
      end else if (quot[a] < (QW + 1)'(MEAN_MIN)) begin
        mean[a] = MEAN_W'(MEAN_MIN);
      end else begin
        mean[a] = quot[a][MEAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      slot     <= '0;
      count    <= '0;
      bit_cnt  <= '0;
      m_tvalid <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sum[a] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            sample <= s_tdata;
            state  <= ST_READ;
          end
        end
        ST_READ: begin
          for (int a = 0; a < AXES; a++) begin
            sum[a] <= sum_next[a];
            dvd[a] <= mag[a];
            neg[a] <= scaled[a][QW-1];
            rem[a] <= '0;
          end
          slot    <= slot_next;
          count   <= count_next;
          bit_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          for (int a = 0; a < AXES; a++) begin
            rem[a] <= rem_next[a];
            dvd[a] <= {dvd[a][QW-2:0], ge[a]};
          end
          bit_cnt <= bit_cnt + BIT_W'(1);
          if (bit_cnt == BIT_W'(QW - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {used, mean[2], mean[1], mean[0]};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(WINDOW)) else $error("fill count beyond window");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= SLOT_W'(WINDOW - 1)) else $error("slot pointer beyond window");

  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_READ && !s_tready)
    else $error("accepted sample not followed by ring read");

  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ && !full |=> count == $past(count) + CNT_W'(1))
    else $error("fill count did not advance during first pass");
`endif

endmodule
